>>> sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define UPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define UPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/upc_pkg.sv
package upc_pkg;

   // Character codes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_TILDE   = 8'h7E;

   // Register map (word index)
   localparam logic REG_MODE = 1'b0;

   // Mode values
   localparam logic MODE_ENCODE = 1'b0;

   // Escape tracking codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HIGH    = 2'd1;
   localparam logic [1:0] PH_LOW     = 2'd2;
   localparam logic [1:0] PH_BAD_LOW = 2'd3;

   // One result byte waiting to go out
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } entry_type;

   // Digit value 0..35; bit 6 set when the byte is a digit
   function automatic logic [6:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      logic       ok;
      v  = 8'd0;
      ok = 1'b0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v  = c - 8'd55;
         ok = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v  = c - 8'd87;
         ok = 1'b1;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v  = c - 8'd48;
         ok = 1'b1;
      end
      return {ok, v[5:0]};
   endfunction

   // Upper-case hex character of a nibble
   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      logic [7:0] w;
      w = {4'd0, n};
      return (n > 4'd9) ? w + 8'd55 : w + 8'd48;
   endfunction

   function automatic logic is_unreserved(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER ||
             c == CH_DOT || c == CH_TILDE;
   endfunction

endpackage

>>> sv/url_percent_codec.sv
// The first result byte is registered and valid in the cycle after its item is accepted.
// One result byte per cycle while rsp_tready is high; the three-entry result buffer holds
// an item's results (1 to 3) and drains one entry a cycle; a new item is taken once the
// buffer is empty or its last entry is leaving; escape prefix bytes yield no result.
// Reset (synchronous, active high) selects encode mode and clears escape state and buffer.
`include "assert_macros.svh"

module url_percent_codec (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] error
   // Configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import upc_pkg::*;

   logic        mode_ff, mode_in;
   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  high_ff, high_in;
   entry_type   buf_ff [3];
   entry_type   buf_in [3];
   logic [1:0]  count_ff, count_in;

   logic        req_fire, rsp_fire, cfg_wr;
   entry_type   gen [3];
   logic [1:0]  gen_cnt;
   logic [6:0]  dig;
   logic [7:0]  c;
   logic        last;

   assign c          = req_tdata;
   assign last       = req_tlast;
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign req_tready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);
   assign req_fire   = req_tvalid & req_tready;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register read port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MODE) ? {31'd0, mode_ff} : 32'd0;

   // Results of the item at the input
   always_comb begin
      dig      = digit_value(c);
      gen[0]   = '0;
      gen[1]   = '0;
      gen[2]   = '0;
      gen_cnt  = 2'd0;
      phase_in = phase_ff;
      high_in  = high_ff;
      if (mode_ff == MODE_ENCODE) begin
         phase_in = PH_IDLE;
         if (is_unreserved(c)) begin
            gen[0]  = '{data: c, last: last, err: 1'b0};
            gen_cnt = 2'd1;
         end else if (c == CH_SPACE) begin
            gen[0]  = '{data: CH_PLUS, last: last, err: 1'b0};
            gen_cnt = 2'd1;
         end else begin
            gen[0]  = '{data: CH_PERCENT, last: 1'b0, err: 1'b0};
            gen[1]  = '{data: nibble_char(c[7:4]), last: 1'b0, err: 1'b0};
            gen[2]  = '{data: nibble_char(c[3:0]), last: last, err: 1'b0};
            gen_cnt = 2'd3;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (c == CH_PERCENT) begin
                  if (last) begin
                     gen[0]  = '{data: 8'd0, last: 1'b1, err: 1'b1};
                     gen_cnt = 2'd1;
                  end else begin
                     phase_in = PH_HIGH;
                  end
               end else begin
                  gen[0]  = '{data: c, last: last, err: 1'b0};
                  gen_cnt = 2'd1;
               end
            end
            PH_HIGH: begin
               if (last) begin
                  gen[0]   = '{data: 8'd0, last: 1'b1, err: 1'b1};
                  gen_cnt  = 2'd1;
                  phase_in = PH_IDLE;
               end else if (!dig[6]) begin
                  phase_in = PH_BAD_LOW;
                  high_in  = 6'd0;
               end else begin
                  phase_in = PH_LOW;
                  high_in  = dig[5:0];
               end
            end
            PH_LOW: begin
               if (!dig[6]) begin
                  gen[0] = '{data: 8'd0, last: last, err: 1'b1};
               end else begin
                  gen[0] = '{data: {high_ff[3:0], 4'd0} + {2'd0, dig[5:0]},
                             last: last, err: 1'b0};
               end
               gen_cnt  = 2'd1;
               phase_in = PH_IDLE;
               high_in  = 6'd0;
            end
            default: begin
               gen[0]   = '{data: 8'd0, last: last, err: 1'b1};
               gen_cnt  = 2'd1;
               phase_in = PH_IDLE;
               high_in  = 6'd0;
            end
         endcase
         if (last) begin
            phase_in = PH_IDLE;
            high_in  = 6'd0;
         end
      end
   end

   // Result buffer: load on input transfer, else shift on output transfer; also the mode write
   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      mode_in  = mode_ff;
      if (req_fire) begin
         buf_in   = gen;
         count_in = gen_cnt;
      end else if (rsp_fire) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         count_in  = count_ff - 2'd1;
      end
      if (cfg_wr && csr_paddr[2] == REG_MODE) begin
         mode_in = csr_pwdata[0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         phase_ff <= PH_IDLE;
         high_ff  <= 6'd0;
         count_ff <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         if (cfg_wr && csr_paddr[2] == REG_MODE) begin
            phase_ff <= PH_IDLE;
            high_ff  <= 6'd0;
         end else if (req_fire) begin
            phase_ff <= phase_in;
            high_ff  <= high_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = buf_ff[0].data;
   assign rsp_tlast  = buf_ff[0].last;
   assign rsp_tuser  = buf_ff[0].err;

   // Checks
   `UPC_ASSERT(a_ready_room, req_tready |-> (count_ff <= 2'd1), "input taken while buffer full")
   `UPC_ASSERT(a_err_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 8'd0), "error byte not zero")
   `UPC_ASSERT(a_enc_no_esc, (mode_ff == MODE_ENCODE) |-> (phase_ff == PH_IDLE), "escape in encode")
   `UPC_ASSERT_ALWAYS(a_high_clear, (phase_ff == PH_IDLE || phase_ff == PH_HIGH) |=> (reset || phase_ff != PH_IDLE || high_ff == 6'd0), "stale high digit")

endmodule
